/* sv/trdiv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime tester package
// Default sizes and the sequencer state codes.
// ----------------------------------------------------------------------------
package trdiv_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int TABLE_DEPTH_DEF = 8192;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_M5   = 9'b000000010,
    S_SQRT = 9'b000000100,
    S_RD   = 9'b000001000,
    S_CHK  = 9'b000010000,
    S_MT   = 9'b000100000,
    S_ODD  = 9'b001000000,
    S_OD   = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

endpackage

/* sv/trial_division_prime_tester.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime tester
// Tests each candidate against a table of stored primes and then against
// odd divisors above the range already covered, appending new primes.
// ----------------------------------------------------------------------------
// One candidate is worked on at a time. Candidates up to 5 and even ones are
// settled directly in the idle state. Others go through the test by 5, the
// integer square root, a read of each stored table entry from the prime
// memory, and a trial division per divisor, which runs one quotient bit per
// cycle in a shared remainder unit. A result is held in an output register,
// so the next candidate is taken while the previous result waits.
module trial_division_prime_tester
  import trdiv_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // Fields from bit 0: candidate.
  input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // Fields from bit 0: prime_flag, stored, table_full.
  output logic [7:0]                           out_tdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MW = $clog2(VALUE_WIDTH + 1);
  localparam int SB = 2 * ((VALUE_WIDTH - 1) / 2);
  localparam int NIB = (VALUE_WIDTH + 3) / 4;
  localparam logic [VALUE_WIDTH-1:0] TOPBIT = VALUE_WIDTH'(1) << SB;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [MW-1:0] MDONE = MW'(VALUE_WIDTH);

  // Since 16 leaves remainder 1 modulo 5, the nibble sum keeps the remainder.
  function automatic logic [2:0] mod5(input logic [VALUE_WIDTH-1:0] v);
    logic [4*NIB-1:0] w;
    logic [7:0]       s;
    logic [4:0]       t;
    w = (4*NIB)'(v);
    s = '0;
    for (int i = 0; i < NIB; i++) begin
      s = s + 8'(w[4*i +: 4]);
    end
    t = 5'(s[7:4]) + 5'(s[3:0]);
    if (t >= 5'd20) t = t - 5'd20;
    if (t >= 5'd10) t = t - 5'd10;
    if (t >= 5'd5) t = t - 5'd5;
    return t[2:0];
  endfunction

  logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_r;

  state_t                 state_r;
  logic [VALUE_WIDTH-1:0] n_r, bound_r, lt_r, d_r;
  logic [VALUE_WIDTH-1:0] sv_r, root_r, bit_r;
  logic [VALUE_WIDTH-1:0] rem_r, sh_r, dv_r;
  logic [MW-1:0]          mc_r;
  logic [CW-1:0]          cnt_r, k_r;
  logic                   prime_r;
  logic                   out_valid_r, out_prime_r, out_stored_r, out_full_r;

  logic [VALUE_WIDTH:0]   mt;
  logic [VALUE_WIDTH:0]   mdiff;
  logic [VALUE_WIDTH-1:0] sq_sum;
  logic [VALUE_WIDTH-1:0] cand;
  logic                   mod_done, mod_zero, put, m5_zero;

  assign cand     = in_tdata[VALUE_WIDTH-1:0];
  assign mt       = {rem_r, sh_r[VALUE_WIDTH-1]};
  assign mdiff    = mt - {1'b0, dv_r};
  assign mod_done = (mc_r == MDONE);
  assign mod_zero = (rem_r == '0);
  assign m5_zero  = (mod5(n_r) == 3'd0);
  assign sq_sum   = root_r + bit_r;
  assign put      = prime_r && (cnt_r < DEPTH_C);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_full_r, out_stored_r, out_prime_r};

  always_ff @(posedge clk) begin
    rdata_r <= mem[k_r[AW-1:0]];
    if (state_r == S_FIN && (!out_valid_r || out_tready) && put) begin
      mem[cnt_r[AW-1:0]] <= n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!mod_done) begin
      rem_r <= mdiff[VALUE_WIDTH] ? mt[VALUE_WIDTH-1:0] : mdiff[VALUE_WIDTH-1:0];
      sh_r  <= {sh_r[VALUE_WIDTH-2:0], 1'b0};
      mc_r  <= mc_r + MW'(1);
    end
    if (state_r == S_SQRT && bit_r != '0) begin
      if (sv_r >= sq_sum) begin
        sv_r   <= sv_r - sq_sum;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      lt_r        <= VALUE_WIDTH'(2);
      out_valid_r <= 1'b0;
      mc_r        <= MDONE;
      k_r         <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            n_r <= cand;
            if (cand <= VALUE_WIDTH'(5)) begin
              prime_r <= (cand == VALUE_WIDTH'(2)) || (cand == VALUE_WIDTH'(3)) ||
                         (cand == VALUE_WIDTH'(5));
              state_r <= S_FIN;
            end else if (!cand[0]) begin
              prime_r <= 1'b0;
              state_r <= S_FIN;
            end else begin
              state_r <= S_M5;
            end
          end
        end
        S_M5: begin
          if (m5_zero) begin
            prime_r <= 1'b0;
            state_r <= S_FIN;
          end else begin
            sv_r    <= n_r;
            root_r  <= '0;
            bit_r   <= TOPBIT;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (bit_r == '0) begin
            bound_r <= root_r + VALUE_WIDTH'(1);
            k_r     <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= (k_r >= cnt_r) ? S_ODD : S_CHK;
        end
        S_CHK: begin
          k_r <= k_r + CW'(1);
          if (rdata_r == '0 || rdata_r > bound_r) begin
            state_r <= S_RD;
          end else begin
            rem_r   <= '0;
            sh_r    <= n_r;
            dv_r    <= rdata_r;
            mc_r    <= '0;
            state_r <= S_MT;
          end
        end
        S_MT: begin
          if (mod_done) begin
            if (mod_zero) begin
              prime_r <= 1'b0;
              state_r <= S_FIN;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_ODD: begin
          if (bound_r > lt_r) begin
            d_r     <= lt_r[0] ? lt_r : lt_r + VALUE_WIDTH'(1);
            mc_r    <= MDONE;
            rem_r   <= VALUE_WIDTH'(1);
            state_r <= S_OD;
          end else begin
            prime_r <= 1'b1;
            state_r <= S_FIN;
          end
        end
        S_OD: begin
          if (mod_done) begin
            if (mod_zero) begin
              prime_r <= 1'b0;
              state_r <= S_FIN;
            end else if (d_r > bound_r) begin
              lt_r    <= bound_r;
              prime_r <= 1'b1;
              state_r <= S_FIN;
            end else begin
              rem_r <= '0;
              sh_r  <= n_r;
              dv_r  <= d_r;
              mc_r  <= '0;
              d_r   <= d_r + VALUE_WIDTH'(2);
            end
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_prime_r  <= prime_r;
            out_stored_r <= put;
            out_full_r   <= ((put ? cnt_r + CW'(1) : cnt_r) == DEPTH_C);
            if (put) begin
              cnt_r <= cnt_r + CW'(1);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= DEPTH_C)
    else $error("prime count above table depth");
  a_stored_prime: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stored_r |-> out_prime_r)
    else $error("stored result that is not prime");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != $past(cnt_r) |-> $past(state_r) == S_FIN)
    else $error("prime count changed outside result write");

endmodule

/* dv/tb_trial_division_prime_tester.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime tester testbench
// Feeds candidates through the input stream and compares every result beat
// with a behavioral predictor. The predictor keeps its own prime table and
// its own covered divisor range. The stimulus is mostly ascending runs of
// small numbers, with small random values and large multiples of three mixed
// in. The sender works in bursts, and the receiver stalls at random and once
// for a long stretch.
// ----------------------------------------------------------------------------
module tb_trial_division_prime_tester;
  import trdiv_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;
  localparam int DEPTH = TABLE_DEPTH_DEF;

  typedef struct packed {
    bit table_full;
    bit stored;
    bit prime_flag;
  } verdict_t;

  class prime_scoreboard;
    bit [VW-1:0] known_primes[$];
    longint unsigned covered_top;
    verdict_t pending_verdicts[$];

    function new();
      covered_top = 2;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned b;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= root + b) begin
          v = v - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      return root;
    endfunction

    function bit prime_test(longint unsigned n);
      longint unsigned bound;
      longint unsigned d;
      if (n <= 5) return (n == 2 || n == 3 || n == 5);
      if (n[0] == 1'b0 || n % 5 == 0) return 0;
      bound = 1 + isqrt(n);
      foreach (known_primes[k]) begin
        if (known_primes[k] != 0 && known_primes[k] <= bound &&
            n % known_primes[k] == 0) return 0;
      end
      if (bound > covered_top) begin
        d = covered_top[0] ? covered_top : covered_top + 1;
        while (d <= bound) begin
          if (d != 0 && n % d == 0) return 0;
          d += 2;
        end
        covered_top = bound & ((64'd1 << VW) - 1);
      end
      return 1;
    endfunction

    function void note_candidate(bit [VW-1:0] cand);
      verdict_t v;
      v.prime_flag = prime_test(cand);
      v.stored = 0;
      if (v.prime_flag && known_primes.size() < DEPTH) begin
        known_primes.push_back(cand);
        v.stored = 1;
      end
      v.table_full = (known_primes.size() >= DEPTH);
      pending_verdicts.push_back(v);
    endfunction

    function bit check_result(bit [7:0] data, output string msg);
      verdict_t e;
      if (pending_verdicts.size() == 0) begin
        msg = $sformatf("result beat %02h with nothing pending", data);
        return 0;
      end
      e = pending_verdicts.pop_front();
      if (data[2:0] != e) begin
        msg = $sformatf("got prime=%0b stored=%0b full=%0b, want %0b %0b %0b",
                        data[0], data[1], data[2], e.prime_flag, e.stored, e.table_full);
        return 0;
      end
      return 1;
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [VW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [7:0] out_tdata;

  prime_scoreboard sb = new();
  int mismatches = 0;
  bit long_hold = 0;
  int burst_left = 4;
  longint unsigned walk = 7;

  always #5 clk = ~clk;

  trial_division_prime_tester u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    string msg;
    if (rst_n && out_tvalid && out_tready) begin
      if (!sb.check_result(out_tdata, msg)) report_mismatch(msg);
    end
  end

  initial begin
    int quiet;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 0;
        repeat (2000) @(posedge clk);
        long_hold = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1;
        quiet = $urandom_range(10, 40);
        repeat (quiet) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 2) != 0);
        @(posedge clk);
      end
    end
  end

  task automatic send_candidate(bit [VW-1:0] cand);
    in_tdata <= cand;
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_candidate(cand);
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    bit [VW-1:0] directed[$] = '{0, 1, 2, 3, 4, 5, 6, 7, 9, 10, 11, 13, 25, 49,
                                 121, 169, 173, 32'hFFFFFFFF, 32'hFFFFFFFE,
                                 32'hAAAAAAAA, 32'h55555555, 32'h80000001};
    bit [VW-1:0] c;
    int kind;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[i]) send_candidate(directed[i]);
    drain();
    for (int i = 0; i < 100; i++) begin
      if (i == 40) begin
        long_hold = 1;
        burst_left = 30;
      end
      if (i == 70) drain();
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        walk = walk + $urandom_range(1, 40);
        if (walk > 30000) walk = 7;
        c = walk;
      end else if (kind < 8) begin
        c = $urandom_range(0, 2000);
      end else begin
        c = 3 * ({$urandom} % 32'h55555555 | 32'd1);
      end
      send_candidate(c);
    end
    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
